/* src/rv32i_integer_execute_macros.svh */
// Assertion helpers shared by the execute block.
`ifndef RV32I_INTEGER_EXECUTE_MACROS_SVH
`define RV32I_INTEGER_EXECUTE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RVX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rvx_pkg.sv */
package rvx_pkg;

  // Field widths fixed by the instruction set.
  localparam int XLEN        = 32;
  localparam int PC_W        = 30;
  localparam int REG_NUM_W   = 5;
  localparam int REG_COUNT_W = 6;

  // Defaults for the top-level parameters.
  localparam int REG_COUNT_DEF = 32;
  localparam int QUEUE_DEPTH   = 2;

  // Major opcodes, bits 6..2 of the instruction word.
  localparam logic [4:0] OPC_LUI   = 5'b01101;
  localparam logic [4:0] OPC_AUIPC = 5'b00101;
  localparam logic [4:0] OPC_OPIMM = 5'b00100;
  localparam logic [4:0] OPC_OP    = 5'b01100;

  // funct7 values.
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 values.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_EXEC   = 2'd0,
    ST_UNSUP  = 2'd1,
    ST_COMPR  = 2'd2,
    ST_HALTED = 2'd3
  } status_t;

  // ALU operations carried out by the back end.
  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU,
    ALU_XOR, ALU_SRL, ALU_SRA, ALU_OR, ALU_AND
  } alu_op_t;

  // Decoded request passed from the front end to the back end.
  typedef struct packed {
    logic [PC_W-1:0]      pc;
    status_t              status;
    alu_op_t              op;
    logic                 a_reg;
    logic                 b_reg;
    logic                 wr_en;
    logic [REG_NUM_W-1:0] rd;
    logic [REG_NUM_W-1:0] rs1;
    logic [REG_NUM_W-1:0] rs2;
    logic [XLEN-1:0]      a_const;
    logic [XLEN-1:0]      b_const;
  } ex_req_t;

endpackage

/* src/rvx_front.sv */
module rvx_front #(
  parameter int REG_COUNT = rvx_pkg::REG_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [31:0]         instr_word,
  output rvx_pkg::ex_req_t    req
);
  import rvx_pkg::*;

  logic [PC_W-1:0] pc;
  logic            halted;

  logic [4:0]           op5;
  logic [REG_NUM_W-1:0] rd;
  logic [REG_NUM_W-1:0] rs1;
  logic [REG_NUM_W-1:0] rs2;
  logic [2:0]           f3;
  logic [6:0]           f7;
  logic [XLEN-1:0]      imm_i;
  logic [XLEN-1:0]      imm_u;
  logic                 rd_ok;
  logic                 rs1_ok;
  logic                 rs2_ok;
  logic                 ok;
  logic                 compressed;

  // Instruction fields.
  assign op5        = instr_word[6:2];
  assign rd         = instr_word[11:7];
  assign f3         = instr_word[14:12];
  assign rs1        = instr_word[19:15];
  assign rs2        = instr_word[24:20];
  assign f7         = instr_word[31:25];
  assign imm_i      = {{20{instr_word[31]}}, instr_word[31:20]};
  assign imm_u      = {instr_word[31:12], 12'h000};
  assign compressed = (instr_word[1:0] != 2'b11);

  // Register numbers beyond the implemented file make the encoding unsupported.
  assign rd_ok  = (REG_COUNT_W'(rd)  < REG_COUNT_W'(REG_COUNT));
  assign rs1_ok = (REG_COUNT_W'(rs1) < REG_COUNT_W'(REG_COUNT));
  assign rs2_ok = (REG_COUNT_W'(rs2) < REG_COUNT_W'(REG_COUNT));

  // Classify the word and pick operand sources and the ALU operation.
  always_comb begin
    ok          = 1'b0;
    req.pc      = pc;
    req.op      = ALU_ADD;
    req.a_reg   = 1'b0;
    req.b_reg   = 1'b0;
    req.rd      = rd;
    req.rs1     = rs1;
    req.rs2     = rs2;
    req.a_const = '0;
    req.b_const = imm_i;
    unique case (op5)
      OPC_LUI: begin
        ok          = rd_ok;
        req.b_const = imm_u;
      end
      OPC_AUIPC: begin
        ok          = rd_ok;
        req.a_const = {pc, 2'b00};
        req.b_const = imm_u;
      end
      OPC_OPIMM: begin
        ok        = rd_ok && rs1_ok;
        req.a_reg = 1'b1;
        unique case (f3)
          F3_ADD:  req.op = ALU_ADD;
          F3_SLT:  req.op = ALU_SLT;
          F3_SLTU: req.op = ALU_SLTU;
          F3_XOR:  req.op = ALU_XOR;
          F3_OR:   req.op = ALU_OR;
          F3_AND:  req.op = ALU_AND;
          F3_SLL: begin
            req.op = ALU_SLL;
            if (f7 != F7_BASE) begin
              ok = 1'b0;
            end
          end
          default: begin
            if (f7 == F7_BASE) begin
              req.op = ALU_SRL;
            end else if (f7 == F7_ALT) begin
              req.op = ALU_SRA;
            end else begin
              ok = 1'b0;
            end
          end
        endcase
      end
      OPC_OP: begin
        ok        = rd_ok && rs1_ok && rs2_ok;
        req.a_reg = 1'b1;
        req.b_reg = 1'b1;
        if (f7 == F7_BASE) begin
          unique case (f3)
            F3_ADD:  req.op = ALU_ADD;
            F3_SLL:  req.op = ALU_SLL;
            F3_SLT:  req.op = ALU_SLT;
            F3_SLTU: req.op = ALU_SLTU;
            F3_XOR:  req.op = ALU_XOR;
            F3_SR:   req.op = ALU_SRL;
            F3_OR:   req.op = ALU_OR;
            default: req.op = ALU_AND;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          req.op = ALU_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          req.op = ALU_SRA;
        end else begin
          ok = 1'b0;
        end
      end
      default: ok = 1'b0;
    endcase

    // Status and write enable, with halt and compressed taking priority.
    priority if (halted) begin
      req.status = ST_HALTED;
      req.wr_en  = 1'b0;
    end else if (compressed) begin
      req.status = ST_COMPR;
      req.wr_en  = 1'b0;
    end else if (ok) begin
      req.status = ST_EXEC;
      req.wr_en  = (rd != '0);
    end else begin
      req.status = ST_UNSUP;
      req.wr_en  = 1'b0;
    end
  end

  // Program counter and halt flag advance as each request is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= '0;
      halted <= 1'b0;
    end else if (accept && !halted) begin
      if (compressed) begin
        halted <= 1'b1;
      end else begin
        pc <= pc + PC_W'(1);
      end
    end
  end

endmodule

/* src/rvx_fifo.sv */
module rvx_fifo #(
  parameter int DEPTH = rvx_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rvx_pkg::ex_req_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output rvx_pkg::ex_req_t head
);
  import rvx_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ex_req_t          slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  // Storage slots take the pushed request.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* src/rvx_back.sv */
`include "rv32i_integer_execute_macros.svh"

module rvx_back #(
  parameter int REG_COUNT = rvx_pkg::REG_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  rvx_pkg::ex_req_t             q_head,
  output logic                         q_pop,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [rvx_pkg::PC_W-1:0]     instr_index,
  output logic                         reg_written,
  output logic [rvx_pkg::REG_NUM_W-1:0] dest_reg,
  output logic [rvx_pkg::XLEN-1:0]     dest_value,
  output logic [1:0]                   status
);
  import rvx_pkg::*;

  localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // Register file storage; an entry never written reads as zero.
  logic [XLEN-1:0]      regs [REG_COUNT];
  logic [REG_COUNT-1:0] reg_vld;

  // Operand stage.
  logic            r_valid;
  ex_req_t         r_req;
  logic [XLEN-1:0] r_data_a;
  logic [XLEN-1:0] r_data_b;
  logic            r_vld_a;
  logic            r_vld_b;
  logic            r_adv;

  // Most recent register write, used for bypass.
  logic             lw_valid;
  logic [IDX_W-1:0] lw_addr;
  logic [XLEN-1:0]  lw_data;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] ra_idx;
  logic [IDX_W-1:0] rb_idx;
  logic [IDX_W-1:0] head_a_idx;
  logic [IDX_W-1:0] head_b_idx;
  logic [XLEN-1:0]  rf_a;
  logic [XLEN-1:0]  rf_b;
  logic [XLEN-1:0]  op_a;
  logic [XLEN-1:0]  op_b;
  logic [4:0]       shamt;
  logic [XLEN-1:0]  alu_res;

  // Handshake between queue, operand stage and output register.
  assign r_adv = r_valid && (!result_valid || result_ready);
  assign q_pop = !q_empty && (!r_valid || r_adv);

  assign head_a_idx = q_head.rs1[IDX_W-1:0];
  assign head_b_idx = q_head.rs2[IDX_W-1:0];
  assign ra_idx     = r_req.rs1[IDX_W-1:0];
  assign rb_idx     = r_req.rs2[IDX_W-1:0];
  assign rd_idx     = r_req.rd[IDX_W-1:0];

  // Register file read as a request leaves the queue.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      r_req    <= q_head;
      r_data_a <= regs[head_a_idx];
      r_data_b <= regs[head_b_idx];
      r_vld_a  <= reg_vld[head_a_idx];
      r_vld_b  <= reg_vld[head_b_idx];
    end
  end

  // Register file write as a request leaves the operand stage.
  always_ff @(posedge clk) begin
    if (r_adv && r_req.wr_en) begin
      regs[rd_idx] <= alu_res;
      lw_addr      <= rd_idx;
      lw_data      <= alu_res;
    end
  end

  // Valid bits and bypass flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_vld  <= '0;
      lw_valid <= 1'b0;
      r_valid  <= 1'b0;
    end else begin
      if (r_adv && r_req.wr_en) begin
        reg_vld[rd_idx] <= 1'b1;
        lw_valid        <= 1'b1;
      end
      if (q_pop) begin
        r_valid <= 1'b1;
      end else if (r_adv) begin
        r_valid <= 1'b0;
      end
    end
  end

  // Operand selection; a write made on the read edge is bypassed.
  always_comb begin
    if (lw_valid && lw_addr == ra_idx) begin
      rf_a = lw_data;
    end else begin
      rf_a = r_vld_a ? r_data_a : '0;
    end
    if (lw_valid && lw_addr == rb_idx) begin
      rf_b = lw_data;
    end else begin
      rf_b = r_vld_b ? r_data_b : '0;
    end
    op_a  = r_req.a_reg ? rf_a : r_req.a_const;
    op_b  = r_req.b_reg ? rf_b : r_req.b_const;
    shamt = op_b[4:0];
  end

  // ALU.
  always_comb begin
    unique case (r_req.op)
      ALU_ADD:  alu_res = op_a + op_b;
      ALU_SUB:  alu_res = op_a - op_b;
      ALU_SLL:  alu_res = op_a << shamt;
      ALU_SLT:  alu_res = XLEN'($signed(op_a) < $signed(op_b));
      ALU_SLTU: alu_res = XLEN'(op_a < op_b);
      ALU_XOR:  alu_res = op_a ^ op_b;
      ALU_SRL:  alu_res = op_a >> shamt;
      ALU_SRA:  alu_res = XLEN'($signed(op_a) >>> shamt);
      ALU_OR:   alu_res = op_a | op_b;
      ALU_AND:  alu_res = op_a & op_b;
      default:  alu_res = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (r_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r_adv) begin
      instr_index <= r_req.pc;
      reg_written <= r_req.wr_en;
      dest_reg    <= r_req.wr_en ? r_req.rd : '0;
      dest_value  <= r_req.wr_en ? alu_res : '0;
      status      <= r_req.status;
    end
  end

  // Only executed requests may report a register write.
  `RVX_ASSERT_NOW(a_write_needs_exec, result_valid && reg_written, status == ST_EXEC, "write reported on a request that did not execute")
  // Register zero is never written.
  `RVX_ASSERT_NOW(a_no_x0_write, r_adv && r_req.wr_en, r_req.rd != '0, "write to register zero")
  // A written entry is marked valid on the following cycle.
  `RVX_ASSERT_NEXT(a_vld_after_write, r_adv && r_req.wr_en, reg_vld[$past(rd_idx)], "written entry not marked valid")
  // The bypass register follows the last write.
  `RVX_ASSERT_NEXT(a_bypass_tracks, r_adv && r_req.wr_en, lw_valid && lw_data == $past(alu_res), "bypass register lost the last write")

endmodule

/* src/rv32i_integer_execute.sv */
// Channel  | Direction | Handshake                    | Payload
// instr    | in        | instr_valid / instr_ready    | instr_word
// result   | out       | result_valid / result_ready  | instr_index, reg_written, dest_reg,
//          |           |                              | dest_value, status
//
// One instruction per cycle is sustained when results are taken every cycle.
// A request passes through a queue slot and the operand stage into the output register
// before it is presented on the result channel; the bypass of the last register write
// keeps dependent instructions at full rate.
// Synchronous reset clears the program counter, halt flag, queue and register valid bits.
// A stalled result holds the back end; the two-entry queue fills and then drops instr_ready.
module rv32i_integer_execute #(
  parameter int REG_COUNT = rvx_pkg::REG_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          instr_valid,
  output logic                          instr_ready,
  input  logic [31:0]                   instr_word,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [rvx_pkg::PC_W-1:0]      instr_index,
  output logic                          reg_written,
  output logic [rvx_pkg::REG_NUM_W-1:0] dest_reg,
  output logic [rvx_pkg::XLEN-1:0]      dest_value,
  output logic [1:0]                    status
);
  import rvx_pkg::*;

  ex_req_t dec_req;
  ex_req_t q_head;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  logic    accept;

  assign instr_ready = !q_full;
  assign accept      = instr_valid && instr_ready;

  // Front end: decode and program counter.
  rvx_front #(
    .REG_COUNT(REG_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .instr_word(instr_word),
    .req       (dec_req)
  );

  // Queue between decode and execute.
  rvx_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(dec_req),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back end: register file, ALU and result register.
  rvx_back #(
    .REG_COUNT(REG_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .instr_index (instr_index),
    .reg_written (reg_written),
    .dest_reg    (dest_reg),
    .dest_value  (dest_value),
    .status      (status)
  );

endmodule

/* bench/rv32i_integer_execute_checker.sv */
// Watches both channels of the execute block, runs its own copy of the
// architectural state and compares every result against the oldest prediction.
module rv32i_integer_execute_checker #(
  parameter int REG_COUNT = rvx_pkg::REG_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          instr_valid,
  input  logic                          instr_ready,
  input  logic [31:0]                   instr_word,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  logic [rvx_pkg::PC_W-1:0]      instr_index,
  input  logic                          reg_written,
  input  logic [rvx_pkg::REG_NUM_W-1:0] dest_reg,
  input  logic [rvx_pkg::XLEN-1:0]      dest_value,
  input  logic [1:0]                    status,
  output int unsigned                   outstanding,
  output int unsigned                   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import rvx_pkg::*;

  // What one executed request is expected to report.
  typedef struct packed {
    logic [PC_W-1:0]      index;
    logic                 wr;
    logic [REG_NUM_W-1:0] rd;
    logic [XLEN-1:0]      data;
    status_t              status;
  } exec_result_t;

  // Architectural state as the block should hold it.
  logic [XLEN-1:0] arch_regs [0:31];
  logic [PC_W-1:0] arch_pc;
  logic            arch_halted;

  exec_result_t expected_results[$];
  int unsigned  mismatches = 0;

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Register x0 and numbers past the file size read as zero.
  function automatic logic [XLEN-1:0] reg_value(input logic [REG_NUM_W-1:0] idx);
    if (idx == 0 || idx >= REG_COUNT) return '0;
    return arch_regs[idx];
  endfunction

  // Executes one instruction word against the predicted state.
  task automatic execute_instr(input logic [31:0] w, output exec_result_t r);
    logic [4:0]      opc;
    logic [4:0]      rd;
    logic [4:0]      rs1;
    logic [4:0]      rs2;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] val;
    logic            ok;
    opc = w[6:2];
    rd  = w[11:7];
    f3  = w[14:12];
    rs1 = w[19:15];
    rs2 = w[24:20];
    f7  = w[31:25];
    a   = reg_value(rs1);
    b   = reg_value(rs2);
    imm = {{20{w[31]}}, w[31:20]};
    val = '0;
    ok  = 1'b0;
    r.index  = arch_pc;
    r.wr     = 1'b0;
    r.rd     = '0;
    r.data   = '0;
    r.status = ST_EXEC;

    if (arch_halted) begin
      r.status = ST_HALTED;
    end else if (w[1:0] != 2'b11) begin
      // A compressed encoding stops the block without moving the PC.
      arch_halted = 1'b1;
      r.status = ST_COMPR;
    end else begin
      if (opc == OPC_LUI && rd < REG_COUNT) begin
        val = {w[31:12], 12'h000};
        ok = 1'b1;
      end else if (opc == OPC_AUIPC && rd < REG_COUNT) begin
        val = {arch_pc, 2'b00} + {w[31:12], 12'h000};
        ok = 1'b1;
      end else if (opc == OPC_OPIMM && rd < REG_COUNT && rs1 < REG_COUNT) begin
        ok = 1'b1;
        case (f3)
          F3_ADD:  val = a + imm;
          F3_SLT:  val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
          F3_SLTU: val = (a < imm) ? 32'd1 : 32'd0;
          F3_XOR:  val = a ^ imm;
          F3_OR:   val = a | imm;
          F3_AND:  val = a & imm;
          F3_SLL: begin
            if (f7 == F7_BASE) val = a << rs2;
            else ok = 1'b0;
          end
          default: begin
            if (f7 == F7_BASE) val = a >> rs2;
            else if (f7 == F7_ALT) val = $signed(a) >>> rs2;
            else ok = 1'b0;
          end
        endcase
      end else if (opc == OPC_OP && rd < REG_COUNT && rs1 < REG_COUNT &&
                   rs2 < REG_COUNT) begin
        ok = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  val = a + b;
            F3_SLL:  val = a << b[4:0];
            F3_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: val = (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  val = a ^ b;
            F3_SR:   val = a >> b[4:0];
            F3_OR:   val = a | b;
            default: val = a & b;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          val = a - b;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          val = $signed(a) >>> b[4:0];
        end else begin
          ok = 1'b0;
        end
      end

      // Writes to x0 are dropped but still count as executed.
      if (ok) begin
        if (rd != 0) begin
          arch_regs[rd] = val;
          r.wr   = 1'b1;
          r.rd   = rd;
          r.data = val;
        end
      end else begin
        r.status = ST_UNSUP;
      end
      arch_pc = arch_pc + 1'b1;
    end
  endtask

  // Compares one accepted result with the oldest prediction.
  task automatic check_result();
    exec_result_t want;
    if (expected_results.size() == 0) begin
      report_error($sformatf("result for index %0d with no request outstanding",
                             instr_index));
      return;
    end
    want = expected_results.pop_front();
    if (instr_index !== want.index)
      report_error($sformatf("instr_index got %0d want %0d", instr_index, want.index));
    if (reg_written !== want.wr)
      report_error($sformatf("index %0d reg_written got %b want %b",
                             want.index, reg_written, want.wr));
    if (dest_reg !== want.rd)
      report_error($sformatf("index %0d dest_reg got %0d want %0d",
                             want.index, dest_reg, want.rd));
    if (dest_value !== want.data)
      report_error($sformatf("index %0d dest_value got %h want %h",
                             want.index, dest_value, want.data));
    if (status !== want.status)
      report_error($sformatf("index %0d status got %0d want %0d",
                             want.index, status, want.status));
  endtask

  // Results are checked before the new request of the same edge is predicted.
  always @(posedge clk) begin
    exec_result_t r;
    if (rst) begin
      for (int i = 0; i < 32; i++) arch_regs[i] = '0;
      arch_pc = '0;
      arch_halted = 1'b0;
      expected_results.delete();
    end else begin
      if (result_valid && result_ready) check_result();
      if (instr_valid && instr_ready) begin
        execute_instr(instr_word, r);
        expected_results.push_back(r);
      end
    end
    outstanding <= expected_results.size();
    fail_count  <= mismatches;
  end

endmodule

/* bench/tb.sv */
// Drives instruction requests into the execute block and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rvx_pkg::*;

  localparam int          REG_CNT          = REG_COUNT_DEF;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 250;
  localparam int unsigned LONG_HOLD        = 60;
  localparam int unsigned DRAIN_CYCLES     = 10;

  // Encodings outside the supported set.
  localparam logic [6:0] F7_MULDIV = 7'b0000001;
  localparam logic [4:0] OPC_LOAD  = 5'b00000;

  logic                 clk;
  logic                 rst;
  logic                 instr_valid;
  logic                 instr_ready;
  logic [31:0]          instr_word;
  logic                 result_valid;
  logic                 result_ready;
  logic [PC_W-1:0]      instr_index;
  logic                 reg_written;
  logic [REG_NUM_W-1:0] dest_reg;
  logic [XLEN-1:0]      dest_value;
  logic [1:0]           status;

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;

  rv32i_integer_execute #(.REG_COUNT(REG_CNT)) uut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .instr_word   (instr_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .instr_index  (instr_index),
    .reg_written  (reg_written),
    .dest_reg     (dest_reg),
    .dest_value   (dest_value),
    .status       (status)
  );

  rv32i_integer_execute_checker #(.REG_COUNT(REG_CNT)) u_chk (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .instr_word   (instr_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .instr_index  (instr_index),
    .reg_written  (reg_written),
    .dest_reg     (dest_reg),
    .dest_value   (dest_value),
    .status       (status),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int unsigned hold_left;
    logic        hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [31:0] enc_op(input logic [6:0] f7, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3,
                                         input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_OP, 2'b11};
  endfunction

  function automatic logic [31:0] enc_imm(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd);
    return {imm, rs1, f3, rd, OPC_OPIMM, 2'b11};
  endfunction

  function automatic logic [31:0] enc_upper(input logic [4:0] opc, input logic [19:0] imm,
                                            input logic [4:0] rd);
    return {imm, rd, opc, 2'b11};
  endfunction

  // Mostly low registers, so that requests often depend on recent writes.
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(3) != 0) return 5'($urandom_range(7));
    return 5'($urandom_range(31));
  endfunction

  function automatic logic [11:0] pick_imm();
    case ($urandom_range(5))
      0:       return 12'h000;
      1:       return 12'h7FF;
      2:       return 12'h800;
      3:       return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] pick_upper();
    case ($urandom_range(4))
      0:       return 20'h00000;
      1:       return 20'hFFFFF;
      2:       return 20'h80000;
      default: return 20'($urandom);
    endcase
  endfunction

  // Mostly well-formed instructions with random operands, plus some raw noise.
  function automatic logic [31:0] random_instr();
    int unsigned kind;
    logic [2:0]  f3;
    logic [6:0]  f7;
    kind = $urandom_range(99);
    f3 = 3'($urandom_range(7));
    if (kind < 8) return enc_upper(OPC_LUI, pick_upper(), pick_reg());
    if (kind < 14) return enc_upper(OPC_AUIPC, pick_upper(), pick_reg());
    if (kind < 50) begin
      if (f3 == F3_SLL || f3 == F3_SR) begin
        case ($urandom_range(9))
          0:          f7 = 7'($urandom);
          1, 2, 3, 4: f7 = (f3 == F3_SR) ? F7_ALT : F7_BASE;
          default:    f7 = F7_BASE;
        endcase
        return enc_imm({f7, 5'($urandom)}, pick_reg(), f3, pick_reg());
      end
      return enc_imm(pick_imm(), pick_reg(), f3, pick_reg());
    end
    if (kind < 88) begin
      case ($urandom_range(9))
        0:       f7 = 7'($urandom);
        1, 2, 3: f7 = F7_ALT;
        default: f7 = F7_BASE;
      endcase
      return enc_op(f7, pick_reg(), pick_reg(), f3, pick_reg());
    end
    return $urandom | 32'h3;
  endfunction

  // Offers one request after a random idle gap and waits for its acceptance.
  task automatic send_instr(input logic [31:0] word);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      instr_valid <= 1'b0;
      @(posedge clk);
    end
    instr_valid <= 1'b1;
    instr_word  <= word;
    @(posedge clk);
    while (!instr_ready) @(posedge clk);
  endtask

  // Stops offering requests until every prediction has been matched.
  task automatic wait_drained();
    instr_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] directed[$];
    rst = 1'b1;
    instr_valid = 1'b0;
    instr_word = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Field extremes, every operation, x0 writes and unsupported encodings.
    directed.push_back(enc_upper(OPC_LUI, 20'hFFFFF, 5'd1));
    directed.push_back(enc_upper(OPC_LUI, 20'h80000, 5'd2));
    directed.push_back(enc_imm(12'h7FF, 5'd0, F3_ADD, 5'd3));
    directed.push_back(enc_imm(12'h800, 5'd0, F3_ADD, 5'd4));
    directed.push_back(enc_upper(OPC_AUIPC, 20'hFFFFF, 5'd5));
    directed.push_back(enc_op(F7_BASE, 5'd4, 5'd1, F3_ADD, 5'd6));
    directed.push_back(enc_op(F7_ALT, 5'd3, 5'd0, F3_ADD, 5'd7));
    directed.push_back(enc_op(F7_BASE, 5'd3, 5'd4, F3_SLT, 5'd8));
    directed.push_back(enc_op(F7_BASE, 5'd3, 5'd4, F3_SLTU, 5'd9));
    directed.push_back(enc_imm(12'h000, 5'd4, F3_SLT, 5'd10));
    directed.push_back(enc_imm(12'hFFF, 5'd3, F3_SLTU, 5'd11));
    directed.push_back(enc_imm(12'hFFF, 5'd1, F3_XOR, 5'd12));
    directed.push_back(enc_imm(12'h800, 5'd3, F3_OR, 5'd13));
    directed.push_back(enc_imm(12'h800, 5'd1, F3_AND, 5'd14));
    directed.push_back(enc_imm({F7_BASE, 5'd31}, 5'd3, F3_SLL, 5'd15));
    directed.push_back(enc_imm({F7_BASE, 5'd31}, 5'd2, F3_SR, 5'd16));
    directed.push_back(enc_imm({F7_ALT, 5'd31}, 5'd2, F3_SR, 5'd17));
    directed.push_back(enc_op(F7_BASE, 5'd16, 5'd3, F3_SLL, 5'd18));
    directed.push_back(enc_op(F7_BASE, 5'd3, 5'd2, F3_SR, 5'd19));
    directed.push_back(enc_op(F7_ALT, 5'd3, 5'd2, F3_SR, 5'd20));
    directed.push_back(enc_op(F7_BASE, 5'd2, 5'd1, F3_XOR, 5'd21));
    directed.push_back(enc_op(F7_BASE, 5'd4, 5'd2, F3_OR, 5'd22));
    directed.push_back(enc_op(F7_BASE, 5'd4, 5'd1, F3_AND, 5'd31));
    directed.push_back(enc_op(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd0));
    directed.push_back(enc_imm({F7_ALT, 5'd1}, 5'd3, F3_SLL, 5'd9));
    directed.push_back(enc_op(F7_MULDIV, 5'd2, 5'd1, F3_ADD, 5'd10));
    directed.push_back(enc_upper(OPC_LOAD, 20'h00002, 5'd1));
    foreach (directed[i]) send_instr(directed[i]);
    wait_drained();

    // Random phases with different idle and stall rates, drained in between.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      for (int unsigned i = 0; i < RANDOM_PER_PHASE; i++) begin
        // Hold results off for a while so the block backs up into its input.
        if (phase == 0 && i == 100) hold_req = ~hold_req;
        send_instr(random_instr());
      end
      wait_drained();
    end

    // A compressed word halts the block; everything after it is ignored.
    send_instr($urandom & 32'hFFFF_FFFC);
    send_instr(($urandom & 32'hFFFF_FFFC) | 32'h1);
    for (int i = 0; i < 4; i++) send_instr(random_instr());
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
